// File: design/assert_macros.svh
// Assertion macros shared by the echo responder modules.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: design/ier_pkg.sv
// Shared types and protocol constants for the ICMP echo responder.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ier_pkg;

    // Frame layout (IPv4 header taken as 20 bytes)
    localparam int ETH_HDR_BYTES = 14;
    localparam int IP_HDR_BYTES  = 20;
    localparam int ICMP_START    = ETH_HDR_BYTES + IP_HDR_BYTES;
    localparam int POS_TTL       = 22;
    localparam int POS_IP_CSUM   = 24;
    localparam int POS_ICMP_CSUM = 36;
    localparam int PATCH_BEATS   = 5;

    localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  IP_PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
    localparam logic [7:0]  REPLY_TTL_RESET   = 8'd64;
    localparam logic [3:0]  BEAT_FULL_BYTES   = 4'd8;

    // Controller sequencing states
    typedef enum logic [3:0] {
        ST_COLLECT = 4'b0001,
        ST_FINISH  = 4'b0010,
        ST_EMIT    = 4'b0100,
        ST_TAIL    = 4'b1000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic store;
        logic finish;
        logic load_head;
        logic load_tail;
        logic emit_last;
        logic frame_last;
        logic full_head;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: design/ier_ctrl.sv
// Controller for the ICMP echo responder: head collection, burst and tail sequencing.
// Depends on ier_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ier_ctrl #(
    parameter int ICMP_SPAN = 64,
    localparam int HEAD_BYTES = ier_pkg::ICMP_START + ICMP_SPAN,
    localparam int HEAD_BEATS = (HEAD_BYTES + 7) / 8,
    localparam int IDX_W      = $clog2(HEAD_BEATS)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_beat_last,
    output logic                  s_ready,
    input  wire ier_pkg::status_t status,
    output ier_pkg::cmd_t         cmd,
    output logic [IDX_W-1:0]      wr_idx,
    output logic [IDX_W-1:0]      rd_idx
);
    import ier_pkg::*;

    localparam logic [IDX_W-1:0] LAST_BEAT = IDX_W'(HEAD_BEATS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic             frame_last_reg, frame_last_next;
    logic             s_accept;
    logic             head_done;

    assign s_accept  = s_valid && s_ready;
    assign head_done = s_beat_last || (wr_idx_reg == LAST_BEAT);
    assign wr_idx    = wr_idx_reg;
    assign rd_idx    = rd_idx_reg;

    // Decode state into handshake and datapath commands
    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.frame_last = frame_last_reg;
        cmd.full_head  = (last_idx_reg == LAST_BEAT);
        cmd.emit_last  = frame_last_reg && (rd_idx_reg == last_idx_reg);
        case (state_reg)
            ST_COLLECT: begin
                s_ready   = 1'b1;
                cmd.store = s_valid;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
            end
            ST_EMIT: begin
                cmd.load_head = status.out_free;
            end
            ST_TAIL: begin
                s_ready       = status.out_free;
                cmd.load_tail = s_valid && status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Advance the sequencer
    always_comb begin
        state_next      = state_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        last_idx_next   = last_idx_reg;
        frame_last_next = frame_last_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_accept) begin
                    if (head_done) begin
                        last_idx_next   = wr_idx_reg;
                        frame_last_next = s_beat_last;
                        wr_idx_next     = '0;
                        state_next      = ST_FINISH;
                    end else begin
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                rd_idx_next = '0;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    if (rd_idx_reg == last_idx_reg) begin
                        state_next = frame_last_reg ? ST_COLLECT : ST_TAIL;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                if (s_accept && s_beat_last) begin
                    state_next = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_COLLECT;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            last_idx_reg   <= '0;
            frame_last_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            last_idx_reg   <= last_idx_next;
            frame_last_reg <= frame_last_next;
        end
    end

    // Burst never reads past the final held beat
    `ASSERT_PROP(a_emit_in_range, aclk, aresetn, (state_reg == ST_EMIT) |-> (rd_idx_reg <= last_idx_reg), "burst index beyond held beats")
    // A beat into the final head slot closes the head
    `ASSERT_PROP(a_head_closes, aclk, aresetn, (cmd.store && wr_idx_reg == LAST_BEAT) |=> (state_reg == ST_FINISH), "head slot overrun")
    // The checksum fold step is followed by the burst in the next cycle
    `ASSERT_PROP(a_finish_once, aclk, aresetn, (state_reg == ST_FINISH) |=> (state_reg == ST_EMIT), "finish step not followed by burst")

endmodule

`default_nettype wire

// File: design/ier_datapath.sv
// Datapath for the ICMP echo responder: head buffer, running checksums, reply patching
// and the output register. Depends on ier_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ier_datapath #(
    parameter int ICMP_SPAN = 64,
    localparam int HEAD_BYTES = ier_pkg::ICMP_START + ICMP_SPAN,
    localparam int HEAD_BEATS = (HEAD_BYTES + 7) / 8,
    localparam int IDX_W      = $clog2(HEAD_BEATS),
    localparam int POS_W      = IDX_W + 3,
    localparam int ACC_W      = 16 + $clog2(4 * HEAD_BEATS)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ier_pkg::cmd_t    cmd,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire logic [IDX_W-1:0] rd_idx,
    output ier_pkg::status_t      status,
    input  wire logic             cfg_wr_en,
    input  wire logic [7:0]       cfg_wr_data,
    input  wire logic [63:0]      s_beat_data,
    input  wire logic [3:0]       s_beat_bytes,
    input  wire logic             s_beat_last,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [63:0]           m_out_data,
    output logic [3:0]            m_out_bytes,
    output logic                  m_out_last,
    output logic                  m_verdict
);
    import ier_pkg::*;

    // Valid bytes the final head beat must carry for a full-length frame
    localparam logic [3:0] TAIL_NEED = 4'(HEAD_BYTES - 8 * (HEAD_BEATS - 1));

    logic [63:0]      head_reg  [HEAD_BEATS];
    logic [3:0]       bytes_reg [HEAD_BEATS];
    logic [3:0]       last_bytes_reg;
    logic [ACC_W-1:0] icmp_acc_reg, icmp_acc_next;
    logic [ACC_W-1:0] ip_acc_reg, ip_acc_next;
    logic [15:0]      icmp_csum_reg;
    logic [15:0]      ip_csum_reg;
    logic             verdict_reg;
    logic [7:0]       reply_ttl_reg;
    logic [63:0]      m_data_reg;
    logic [3:0]       m_bytes_reg;
    logic             m_last_reg;
    logic             m_verdict_reg;
    logic             m_valid_reg, m_valid_next;

    logic [7:0]       icmp_byte [8];
    logic [7:0]       ip_byte   [8];
    logic [17:0]      icmp_part;
    logic [17:0]      ip_part;
    logic [3:0]       last_clamped;
    logic             candidate;
    logic [63:0]      patched [PATCH_BEATS];
    logic [63:0]      head_beat;

    // Fold a wide ones-complement sum to 16 bits
    function automatic logic [15:0] fold_sum(input logic [ACC_W-1:0] acc);
        logic [16:0] first;
        logic [15:0] second;
        first  = {1'b0, acc[15:0]} + 17'(acc[ACC_W-1:16]);
        second = first[15:0] + 16'(first[16]);
        return second;
    endfunction

    // Hold the reply TTL
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reply_ttl_reg <= REPLY_TTL_RESET;
        end else if (cfg_wr_en) begin
            reply_ttl_reg <= cfg_wr_data;
        end
    end

    // Mask each lane of the incoming beat into the two checksum spans
    always_comb begin
        logic [POS_W-1:0] pos;
        logic [7:0]       lane_byte;
        icmp_part = '0;
        ip_part   = '0;
        for (int l = 0; l < 8; l++) begin
            pos       = {wr_idx, 3'(l)};
            lane_byte = s_beat_data[63 - 8 * l -: 8];
            if (int'(pos) >= ICMP_START && int'(pos) < HEAD_BYTES &&
                int'(pos) != ICMP_START && int'(pos) != POS_ICMP_CSUM &&
                int'(pos) != POS_ICMP_CSUM + 1) begin
                icmp_byte[l] = lane_byte;
            end else begin
                icmp_byte[l] = 8'h00;
            end
            if (int'(pos) == POS_TTL) begin
                ip_byte[l] = reply_ttl_reg;
            end else if (int'(pos) >= ETH_HDR_BYTES && int'(pos) < ICMP_START &&
                         int'(pos) != POS_IP_CSUM && int'(pos) != POS_IP_CSUM + 1) begin
                ip_byte[l] = lane_byte;
            end else begin
                ip_byte[l] = 8'h00;
            end
        end
        for (int w = 0; w < 4; w++) begin
            icmp_part = icmp_part + 18'({icmp_byte[2 * w], icmp_byte[2 * w + 1]});
            ip_part   = ip_part + 18'({ip_byte[2 * w], ip_byte[2 * w + 1]});
        end
        icmp_acc_next = ((wr_idx == '0) ? '0 : icmp_acc_reg) + ACC_W'(icmp_part);
        ip_acc_next   = ((wr_idx == '0) ? '0 : ip_acc_reg) + ACC_W'(ip_part);
    end

    // Store head beats and accumulate the sums
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            head_reg[wr_idx]  <= s_beat_data;
            bytes_reg[wr_idx] <= s_beat_bytes;
            last_bytes_reg    <= s_beat_bytes;
            icmp_acc_reg      <= icmp_acc_next;
            ip_acc_reg        <= ip_acc_next;
        end
    end

    // Judge the frame from the held head
    always_comb begin
        last_clamped = (last_bytes_reg > BEAT_FULL_BYTES) ? BEAT_FULL_BYTES : last_bytes_reg;
        candidate = cmd.full_head &&
                    (!cmd.frame_last || last_clamped >= TAIL_NEED) &&
                    head_reg[1][31:16] == ETHERTYPE_IPV4 &&
                    head_reg[2][7:0] == IP_PROTO_ICMP &&
                    head_reg[4][47:40] == ICMP_ECHO_REQUEST;
    end

    // Latch verdict and final checksums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            verdict_reg <= 1'b0;
        end else if (cmd.finish) begin
            verdict_reg <= candidate;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            icmp_csum_reg <= ~fold_sum(icmp_acc_reg);
            ip_csum_reg   <= ~fold_sum(ip_acc_reg);
        end
    end

    // Build reply beats: MAC swap, TTL, IP checksum, address swap, ICMP type and checksum
    always_comb begin
        patched[0] = {head_reg[0][15:0], head_reg[1][63:32], head_reg[0][63:48]};
        patched[1] = {head_reg[0][47:16], head_reg[1][31:0]};
        patched[2] = {head_reg[2][63:16], reply_ttl_reg, head_reg[2][7:0]};
        patched[3] = {ip_csum_reg, head_reg[3][15:0], head_reg[4][63:48],
                      head_reg[3][47:32]};
        patched[4] = {head_reg[3][31:16], ICMP_ECHO_REPLY, head_reg[4][39:32],
                      icmp_csum_reg, head_reg[4][15:0]};
        head_beat  = head_reg[rd_idx];
        if (verdict_reg && rd_idx < IDX_W'(PATCH_BEATS)) begin
            head_beat = patched[rd_idx[2:0]];
        end
    end

    // Load the output register from the burst or the tail stream
    always_ff @(posedge aclk) begin
        if (cmd.load_head) begin
            m_data_reg    <= head_beat;
            m_bytes_reg   <= bytes_reg[rd_idx];
            m_last_reg    <= cmd.emit_last;
            m_verdict_reg <= verdict_reg;
        end else if (cmd.load_tail) begin
            m_data_reg    <= s_beat_data;
            m_bytes_reg   <= s_beat_bytes;
            m_last_reg    <= s_beat_last;
            m_verdict_reg <= verdict_reg;
        end
    end

    always_comb begin
        if (cmd.load_head || cmd.load_tail) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_out_data  = m_data_reg;
    assign m_out_bytes = m_bytes_reg;
    assign m_out_last  = m_last_reg;
    assign m_verdict   = m_verdict_reg;

    // A load must never overwrite a transaction still waiting downstream
    `ASSERT_PROP(a_no_overwrite, aclk, aresetn, (cmd.load_head || cmd.load_tail) |-> (!m_valid_reg || m_ready), "output overwritten while stalled")
    // Burst and tail never load in the same cycle
    `ASSERT_NEVER(a_one_source, aclk, aresetn, cmd.load_head && cmd.load_tail, "two output sources at once")

endmodule

`default_nettype wire

// File: design/icmp_echo_responder.sv
// Top level of the ICMP echo responder: controller plus datapath.
// Depends on ier_pkg, ier_ctrl and ier_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The block takes an Ethernet frame as 64-bit beats (earliest byte in bits 63..56) and
// holds the first ceil((34 + ICMP_SPAN) / 8) beats, 13 at the default span, taking one
// beat per cycle while the ICMP and IP checksums accumulate beat by beat. After the
// final head beat (or an earlier last beat) a finish step folds the checksums and
// decides the verdict, then the held beats leave as a burst through the output
// register, one per cycle while the output side is free; no input transaction is
// accepted during the burst. An IPv4 ICMP echo request of full length leaves as an
// echo reply (verdict 1); any other frame leaves unchanged (verdict 0). Tail beats then
// stream through one per cycle while the output side is free. The reply TTL is written
// through cfg_wr_en/cfg_wr_data, reset 64, and should only be changed between frames.
module icmp_echo_responder #(
    parameter int ICMP_SPAN = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_beat_data,
    input  wire logic [3:0]  s_beat_bytes,
    input  wire logic        s_beat_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_data,
    output logic [3:0]       m_out_bytes,
    output logic             m_out_last,
    output logic             m_verdict
);
    import ier_pkg::*;

    localparam int HEAD_BEATS = (ICMP_START + ICMP_SPAN + 7) / 8;
    localparam int IDX_W      = $clog2(HEAD_BEATS);

    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    // Sequence head collection, burst and tail
    ier_ctrl #(
        .ICMP_SPAN (ICMP_SPAN)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_beat_last (s_beat_last),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd),
        .wr_idx      (wr_idx),
        .rd_idx      (rd_idx)
    );

    // Hold, check, patch and emit beats
    ier_datapath #(
        .ICMP_SPAN (ICMP_SPAN)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .wr_idx       (wr_idx),
        .rd_idx       (rd_idx),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_beat_data  (s_beat_data),
        .s_beat_bytes (s_beat_bytes),
        .s_beat_last  (s_beat_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_data   (m_out_data),
        .m_out_bytes  (m_out_bytes),
        .m_out_last   (m_out_last),
        .m_verdict    (m_verdict)
    );

endmodule

`default_nettype wire
